@@ rtl/core/dvrt_pkg.sv @@
// Package for the distance-vector route table: table sizing, entry and
// evaluation structs, item kinds, outcome codes, register indexes and states.
// Depends on nothing; dvrt_eval, the route table and the testbench import it.
`default_nettype none
package dvrt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int MAC_W       = 48;
    localparam int BAD_W       = 19;
    localparam int HOP_WEIGHT  = 1000;

    localparam logic signed [7:0] METRIC_UNKNOWN = -8'sd128;

    typedef enum logic [2:0] {
        KIND_HEARD  = 3'd0,
        KIND_ADVERT = 3'd1,
        KIND_LOST   = 3'd2,
        KIND_TICK   = 3'd3,
        KIND_LOOKUP = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        OUT_NONE      = 2'd0,
        OUT_INSTALLED = 2'd1,
        OUT_UPDATED   = 2'd2,
        OUT_WITHDRAWN = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        REG_OWN_MAC    = 2'd0,
        REG_MAX_HOPS   = 2'd1,
        REG_HYSTERESIS = 2'd2,
        REG_EXPIRY     = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DIRECT,
        ST_INGEST,
        ST_LOST_FIRST,
        ST_FETCH,
        ST_FETCH_WAIT,
        ST_LOST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [MAC_W-1:0]  dest;
        logic [MAC_W-1:0]  next_hop;
        logic [7:0]        hops;
        logic signed [7:0] metric;
        logic [31:0]       stamp;
    } entry_t;

    typedef struct packed {
        logic                    match;
        logic                    learned;
        logic                    expired;
        logic                    worse;
        logic signed [BAD_W-1:0] bad;
    } eval_t;

endpackage
`default_nettype wire

@@ rtl/core/dvrt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; holds the route table entries.
`default_nettype none
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/dvrt_eval.sv @@
// Shared evaluation unit: compares one table entry against the search key,
// the expiry limit and the worst learned route found so far.
// Depends on dvrt_pkg.
`default_nettype none
module dvrt_eval (
    input  wire dvrt_pkg::entry_t                  ent,
    input  wire logic                              vld,
    input  wire logic [dvrt_pkg::MAC_W-1:0]        key,
    input  wire logic [31:0]                       now,
    input  wire logic [31:0]                       expiry,
    input  wire logic                              w_found,
    input  wire logic signed [dvrt_pkg::BAD_W-1:0] w_bad,
    output dvrt_pkg::eval_t                        ev
);
    import dvrt_pkg::*;

    logic [17:0] prod;
    logic [31:0] age;

    always_comb
    begin
        prod       = 18'(ent.hops) * 18'(HOP_WEIGHT);
        age        = now - ent.stamp;
        ev.match   = vld && (ent.dest == key);
        ev.learned = vld && (ent.hops > 8'd1);
        ev.expired = (age >= expiry);
        ev.bad     = $signed({1'b0, prod}) - $signed({{(BAD_W-8){ent.metric[7]}}, ent.metric});
        ev.worse   = !w_found || (ev.bad > w_bad);
    end

endmodule
`default_nettype wire

@@ rtl/core/distance_vector_route_table.sv @@
// Distance-vector route table for MAC destinations: sequencer, entry
// valid bits, configuration registers and the result register.
// Depends on dvrt_pkg, dvrt_ram and dvrt_eval.
//
// Items arrive on the item channel (item_valid/item_ready) and each one
// gives exactly one transaction on the result channel (result_valid/
// result_ready). The block works on one item at a time; item_ready is high
// only while the sequencer is idle. All table searches go through one RAM
// read port and one evaluation unit, one entry per cycle. Lookup, heard and
// tick items make one pass over the table; an advert from a registered peer
// makes one for the peer and, unless skipped, one for the destination. A
// neighbour-lost item runs one pass for the peer and then, for every learned
// route, one more pass over the table for its next hop. A finished result
// waits in the output register while the receiver stalls; the next item is
// accepted meanwhile and its own result waits until that register frees up.
// Reset clears every valid bit at once and loads the register reset values,
// so the table is usable on the first cycle after reset. The configuration
// port is APB-style with 64-bit data; registers lie at byte offsets 8*i.
`default_nettype none
module distance_vector_route_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [4:0]                    paddr,
    input  wire logic [63:0]                   pwdata,
    output logic      [63:0]                   prdata,
    output logic                               pready,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic [2:0]                    kind,
    input  wire logic [dvrt_pkg::MAC_W-1:0]    peer_mac,
    input  wire logic [dvrt_pkg::MAC_W-1:0]    dest_mac,
    input  wire logic [7:0]                    entry_hops,
    input  wire logic signed [7:0]             entry_metric,
    input  wire logic signed [7:0]             link_metric,
    input  wire logic                          peer_registered,
    input  wire logic [31:0]                   now_ms,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic [1:0]                         outcome,
    output logic                               hit,
    output logic [dvrt_pkg::MAC_W-1:0]         next_hop_mac,
    output logic [7:0]                         hop_count,
    output logic signed [7:0]                  route_metric,
    output logic [5:0]                         removed_count
);
    import dvrt_pkg::*;

    // Configuration registers.
    logic [MAC_W-1:0] own_mac_reg;
    logic [7:0]       max_hops_reg;
    logic [6:0]       hyst_reg;
    logic [31:0]      expiry_reg;
    logic             cfg_we;
    reg_idx_t         cfg_idx;

    // Latched item.
    kind_t             kind_reg;
    logic [MAC_W-1:0]  peer_reg;
    logic [MAC_W-1:0]  dst_reg;
    logic [7:0]        ahops_reg;
    logic signed [7:0] emet_reg;
    logic signed [7:0] lmet_reg;
    logic              preg_reg;
    logic [31:0]       now_reg;

    // Sequencer state.
    state_t            state_reg, state_next;
    state_t            post_reg, post_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rvld_reg, rvld_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic [CNT_W-1:0]  outer_reg, outer_next;
    logic [MAC_W-1:0]  key_reg, key_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  fidx_reg, fidx_next;
    logic [MAC_W-1:0]  m_nh_reg, m_nh_next;
    logic [7:0]        m_hops_reg, m_hops_next;
    logic signed [7:0] m_met_reg, m_met_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              w_found_reg, w_found_next;
    logic [IDX_W-1:0]  w_idx_reg, w_idx_next;
    logic signed [BAD_W-1:0] w_bad_reg, w_bad_next;
    logic [7:0]        w_hops_reg, w_hops_next;
    logic [5:0]        removed_reg, removed_next;
    outcome_t          outcome_reg, outcome_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    // Result register.
    logic              res_valid_reg, res_valid_next;
    outcome_t          res_outcome_reg, res_outcome_next;
    logic              res_hit_reg, res_hit_next;
    logic [MAC_W-1:0]  res_nh_reg, res_nh_next;
    logic [7:0]        res_hops_reg, res_hops_next;
    logic signed [7:0] res_met_reg, res_met_next;
    logic [5:0]        res_removed_reg, res_removed_next;

    // RAM and evaluation unit.
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [$bits(entry_t)-1:0] ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t                  ent;
    eval_t                   ev;

    // Combinational helpers.
    logic              clr_en;
    logic [IDX_W-1:0]  clr_idx;
    logic              set_en;
    logic [IDX_W-1:0]  set_idx;
    logic              inc_removed;
    logic              scan_start;
    entry_t            direct_ent;
    entry_t            learned_ent;
    logic [8:0]        nh9;
    logic signed [7:0] nm;
    logic signed [8:0] nm9;
    logic signed [8:0] lim9;
    logic              adv_skip;
    logic              shorter;
    logic              better;
    outcome_t          code;

    assign ent = entry_t'(ram_rdata);

    dvrt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dvrt_eval u_eval (
        .ent     (ent),
        .vld     (valid_reg[ridx_reg]),
        .key     (key_reg),
        .now     (now_reg),
        .expiry  (expiry_reg),
        .w_found (w_found_reg),
        .w_bad   (w_bad_reg),
        .ev      (ev)
    );

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:3]);

    always_comb
    begin
        case (cfg_idx)
            REG_OWN_MAC:    prdata = 64'(own_mac_reg);
            REG_MAX_HOPS:   prdata = 64'(max_hops_reg);
            REG_HYSTERESIS: prdata = 64'(hyst_reg);
            REG_EXPIRY:     prdata = 64'(expiry_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg  <= '0;
            max_hops_reg <= 8'd8;
            hyst_reg     <= 7'd3;
            expiry_reg   <= 32'd30000;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_OWN_MAC:    own_mac_reg  <= pwdata[MAC_W-1:0];
                REG_MAX_HOPS:   max_hops_reg <= pwdata[7:0];
                REG_HYSTERESIS: hyst_reg     <= pwdata[6:0];
                REG_EXPIRY:     expiry_reg   <= pwdata[31:0];
                default:        own_mac_reg  <= own_mac_reg;
            endcase
        end
    end

    // Item capture.
    assign item_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            kind_reg  <= kind_t'(kind);
            peer_reg  <= peer_mac;
            dst_reg   <= dest_mac;
            ahops_reg <= entry_hops;
            emet_reg  <= entry_metric;
            lmet_reg  <= link_metric;
            preg_reg  <= peer_registered;
            now_reg   <= now_ms;
        end
    end

    // Route arithmetic for the latched item.
    always_comb
    begin
        nh9 = {1'b0, ahops_reg} + 9'd1;
        if (emet_reg == METRIC_UNKNOWN)
        begin
            nm = lmet_reg;
        end
        else if (lmet_reg == METRIC_UNKNOWN)
        begin
            nm = emet_reg;
        end
        else
        begin
            nm = (emet_reg < lmet_reg) ? emet_reg : lmet_reg;
        end
        nm9      = {nm[7], nm};
        lim9     = $signed({m_met_reg[7], m_met_reg}) + $signed({2'b00, hyst_reg});
        adv_skip = (dst_reg == own_mac_reg) || (dst_reg == peer_reg) ||
                   (ahops_reg == 8'd0) || (nh9 > {1'b0, max_hops_reg});
        shorter  = nh9 < {1'b0, m_hops_reg};
        better   = (nh9 == {1'b0, m_hops_reg}) && (nm != METRIC_UNKNOWN) &&
                   ((m_met_reg == METRIC_UNKNOWN) || (nm9 > lim9));
        direct_ent  = '{dest: peer_reg, next_hop: peer_reg, hops: 8'd1,
                        metric: lmet_reg, stamp: now_reg};
        learned_ent = '{dest: dst_reg, next_hop: peer_reg, hops: nh9[7:0],
                        metric: nm, stamp: now_reg};
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        post_next        = post_reg;
        cnt_next         = cnt_reg;
        rvld_next        = 1'b0;
        ridx_next        = ridx_reg;
        outer_next       = outer_reg;
        key_next         = key_reg;
        found_next       = found_reg;
        fidx_next        = fidx_reg;
        m_nh_next        = m_nh_reg;
        m_hops_next      = m_hops_reg;
        m_met_next       = m_met_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        w_found_next     = w_found_reg;
        w_idx_next       = w_idx_reg;
        w_bad_next       = w_bad_reg;
        w_hops_next      = w_hops_reg;
        removed_next     = removed_reg;
        outcome_next     = outcome_reg;
        res_valid_next   = res_valid_reg && !result_ready;
        res_outcome_next = res_outcome_reg;
        res_hit_next     = res_hit_reg;
        res_nh_next      = res_nh_reg;
        res_hops_next    = res_hops_reg;
        res_met_next     = res_met_reg;
        res_removed_next = res_removed_reg;
        ram_we           = 1'b0;
        ram_waddr        = fidx_reg;
        ram_wdata        = direct_ent;
        ram_raddr        = cnt_reg[IDX_W-1:0];
        clr_en           = 1'b0;
        clr_idx          = ridx_reg;
        set_en           = 1'b0;
        set_idx          = fidx_reg;
        inc_removed      = 1'b0;
        scan_start       = 1'b0;
        code             = OUT_NONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next   = ST_START;
                    removed_next = '0;
                    outcome_next = OUT_NONE;
                end
            end

            ST_START:
            begin
                case (kind_reg)
                    KIND_HEARD:
                    begin
                        scan_start = 1'b1;
                        key_next   = peer_reg;
                        post_next  = ST_DIRECT;
                    end
                    KIND_ADVERT:
                    begin
                        if (preg_reg && (peer_reg != own_mac_reg))
                        begin
                            scan_start = 1'b1;
                            key_next   = peer_reg;
                            post_next  = ST_DIRECT;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    KIND_LOST:
                    begin
                        scan_start = 1'b1;
                        key_next   = peer_reg;
                        post_next  = ST_LOST_FIRST;
                    end
                    KIND_TICK:
                    begin
                        scan_start = 1'b1;
                        key_next   = peer_reg;
                        post_next  = ST_DONE;
                    end
                    KIND_LOOKUP:
                    begin
                        scan_start = 1'b1;
                        key_next   = dst_reg;
                        post_next  = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_SCAN:
            begin
                if (cnt_reg != CNT_W'(TABLE_DEPTH))
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    rvld_next = 1'b1;
                    ridx_next = cnt_reg[IDX_W-1:0];
                end
                if (rvld_reg)
                begin
                    if (ev.match && !found_reg)
                    begin
                        found_next  = 1'b1;
                        fidx_next   = ridx_reg;
                        m_nh_next   = ent.next_hop;
                        m_hops_next = ent.hops;
                        m_met_next  = ent.metric;
                    end
                    if (!valid_reg[ridx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = ridx_reg;
                    end
                    if (ev.learned && ev.worse)
                    begin
                        w_found_next = 1'b1;
                        w_idx_next   = ridx_reg;
                        w_bad_next   = ev.bad;
                        w_hops_next  = ent.hops;
                    end
                    if ((kind_reg == KIND_TICK) && ev.learned && ev.expired)
                    begin
                        clr_en      = 1'b1;
                        clr_idx     = ridx_reg;
                        inc_removed = 1'b1;
                    end
                end
                else if (cnt_reg == CNT_W'(TABLE_DEPTH))
                begin
                    state_next = post_reg;
                end
            end

            ST_DIRECT:
            begin
                ram_wdata = direct_ent;
                if (found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = fidx_reg;
                    code      = OUT_UPDATED;
                end
                else if (free_found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = free_idx_reg;
                    code      = OUT_INSTALLED;
                end
                else if (w_found_reg)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = w_idx_reg;
                    inc_removed = 1'b1;
                    code        = OUT_INSTALLED;
                end
                set_en  = ram_we;
                set_idx = ram_waddr;
                if (kind_reg == KIND_HEARD)
                begin
                    outcome_next = code;
                    state_next   = ST_DONE;
                end
                else if (adv_skip)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_start = 1'b1;
                    key_next   = dst_reg;
                    post_next  = ST_INGEST;
                end
            end

            ST_INGEST:
            begin
                ram_wdata = learned_ent;
                if (found_reg)
                begin
                    if (m_hops_reg != 8'd1)
                    begin
                        if ((m_nh_reg == peer_reg) || shorter || better)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = fidx_reg;
                            code      = OUT_UPDATED;
                        end
                    end
                end
                else if (free_found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = free_idx_reg;
                    code      = OUT_INSTALLED;
                end
                else if (w_found_reg && ({1'b0, w_hops_reg} > nh9))
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = w_idx_reg;
                    inc_removed = 1'b1;
                    code        = OUT_INSTALLED;
                end
                set_en       = ram_we;
                set_idx      = ram_waddr;
                outcome_next = code;
                state_next   = ST_DONE;
            end

            ST_LOST_FIRST:
            begin
                if (found_reg && (m_hops_reg == 8'd1))
                begin
                    clr_en      = 1'b1;
                    clr_idx     = fidx_reg;
                    inc_removed = 1'b1;
                end
                outer_next = '0;
                state_next = ST_FETCH;
            end

            ST_FETCH:
            begin
                ram_raddr = outer_reg[IDX_W-1:0];
                if (outer_reg == CNT_W'(TABLE_DEPTH))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_FETCH_WAIT;
                end
            end

            ST_FETCH_WAIT:
            begin
                if (valid_reg[outer_reg[IDX_W-1:0]] && (ent.hops > 8'd1))
                begin
                    scan_start = 1'b1;
                    key_next   = ent.next_hop;
                    post_next  = ST_LOST_CHECK;
                end
                else
                begin
                    outer_next = outer_reg + 1'b1;
                    state_next = ST_FETCH;
                end
            end

            ST_LOST_CHECK:
            begin
                if (!(found_reg && (m_hops_reg == 8'd1)))
                begin
                    clr_en      = 1'b1;
                    clr_idx     = outer_reg[IDX_W-1:0];
                    inc_removed = 1'b1;
                end
                outer_next = outer_reg + 1'b1;
                state_next = ST_FETCH;
            end

            ST_DONE:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_valid_next   = 1'b1;
                    res_removed_next = removed_reg;
                    res_hit_next     = 1'b0;
                    res_nh_next      = '0;
                    res_hops_next    = '0;
                    res_met_next     = '0;
                    case (kind_reg)
                        KIND_HEARD, KIND_ADVERT:
                        begin
                            res_outcome_next = outcome_reg;
                        end
                        KIND_LOST, KIND_TICK:
                        begin
                            res_outcome_next = (removed_reg != 6'd0) ? OUT_WITHDRAWN
                                                                     : OUT_NONE;
                        end
                        KIND_LOOKUP:
                        begin
                            res_outcome_next = OUT_NONE;
                            if (found_reg)
                            begin
                                res_hit_next  = 1'b1;
                                res_nh_next   = m_nh_reg;
                                res_hops_next = m_hops_reg;
                                res_met_next  = m_met_reg;
                            end
                        end
                        default:
                        begin
                            res_outcome_next = OUT_NONE;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (scan_start)
        begin
            cnt_next        = '0;
            found_next      = 1'b0;
            free_found_next = 1'b0;
            w_found_next    = 1'b0;
            state_next      = ST_SCAN;
        end

        if (inc_removed && (removed_reg != 6'd63))
        begin
            removed_next = removed_reg + 6'd1;
        end

        valid_next = valid_reg;
        if (clr_en)
        begin
            valid_next[clr_idx] = 1'b0;
        end
        if (set_en)
        begin
            valid_next[set_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            post_reg        <= ST_DONE;
            cnt_reg         <= '0;
            rvld_reg        <= 1'b0;
            ridx_reg        <= '0;
            outer_reg       <= '0;
            key_reg         <= '0;
            found_reg       <= 1'b0;
            fidx_reg        <= '0;
            m_nh_reg        <= '0;
            m_hops_reg      <= '0;
            m_met_reg       <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            w_found_reg     <= 1'b0;
            w_idx_reg       <= '0;
            w_bad_reg       <= '0;
            w_hops_reg      <= '0;
            removed_reg     <= '0;
            outcome_reg     <= OUT_NONE;
            valid_reg       <= '0;
            res_valid_reg   <= 1'b0;
            res_outcome_reg <= OUT_NONE;
            res_hit_reg     <= 1'b0;
            res_nh_reg      <= '0;
            res_hops_reg    <= '0;
            res_met_reg     <= '0;
            res_removed_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            post_reg        <= post_next;
            cnt_reg         <= cnt_next;
            rvld_reg        <= rvld_next;
            ridx_reg        <= ridx_next;
            outer_reg       <= outer_next;
            key_reg         <= key_next;
            found_reg       <= found_next;
            fidx_reg        <= fidx_next;
            m_nh_reg        <= m_nh_next;
            m_hops_reg      <= m_hops_next;
            m_met_reg       <= m_met_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
            w_found_reg     <= w_found_next;
            w_idx_reg       <= w_idx_next;
            w_bad_reg       <= w_bad_next;
            w_hops_reg      <= w_hops_next;
            removed_reg     <= removed_next;
            outcome_reg     <= outcome_next;
            valid_reg       <= valid_next;
            res_valid_reg   <= res_valid_next;
            res_outcome_reg <= res_outcome_next;
            res_hit_reg     <= res_hit_next;
            res_nh_reg      <= res_nh_next;
            res_hops_reg    <= res_hops_next;
            res_met_reg     <= res_met_next;
            res_removed_reg <= res_removed_next;
        end
    end

    assign result_valid  = res_valid_reg;
    assign outcome       = res_outcome_reg;
    assign hit           = res_hit_reg;
    assign next_hop_mac  = res_nh_reg;
    assign hop_count     = res_hops_reg;
    assign route_metric  = res_met_reg;
    assign removed_count = res_removed_reg;

endmodule
`default_nettype wire

@@ bench/distance_vector_route_table_tb.sv @@
// Self-checking testbench for distance_vector_route_table: a behavioral route
// table predicts every result; directed and random item streams under varied idling.
// Depends on the RTL block and its package dvrt_pkg.
`default_nettype none
module distance_vector_route_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dvrt_pkg::*;

    localparam int DEPTH = 32;
    localparam int STALL_LIMIT = 40000;

    typedef struct {
        logic [2:0]  kind;
        logic [47:0] peer;
        logic [47:0] dest;
        logic [7:0]  hops;
        logic [7:0]  emetric;
        logic [7:0]  lmetric;
        logic        registered;
        logic [31:0] now;
    } route_item_t;

    typedef struct {
        logic [1:0]  outcome;
        logic        hit;
        logic [47:0] next_hop;
        logic [7:0]  hops;
        logic [7:0]  metric;
        logic [5:0]  removed;
    } route_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    logic item_valid = 1'b0;
    logic item_ready;
    logic [2:0] kind = '0;
    logic [47:0] peer_mac = '0, dest_mac = '0;
    logic [7:0] entry_hops = '0;
    logic signed [7:0] entry_metric = '0, link_metric = '0;
    logic peer_registered = 1'b0;
    logic [31:0] now_ms = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic [1:0] outcome;
    logic hit;
    logic [47:0] next_hop_mac;
    logic [7:0] hop_count;
    logic signed [7:0] route_metric;
    logic [5:0] removed_count;

    distance_vector_route_table i_dut (.*);

    always #2 clk = ~clk;

    // Predicted table and register copies.
    logic [47:0] cfg_own_mac;
    int unsigned cfg_max_hops;
    int cfg_hysteresis;
    logic [31:0] cfg_expiry;
    bit          rt_valid [DEPTH];
    logic [47:0] rt_dest [DEPTH];
    logic [47:0] rt_via [DEPTH];
    int unsigned rt_hops [DEPTH];
    int          rt_metric [DEPTH];
    logic [31:0] rt_stamp [DEPTH];

    route_result_t pending_results[$];
    int errors = 0;
    int send_idle = 0, recv_idle = 0;
    int quiet_cycles = 0;
    logic [31:0] clock_ms = 0;
    logic [47:0] peer_pool [8];
    logic [47:0] dest_pool [40];

    function automatic int route_slot(logic [47:0] d);
        for (int i = 0; i < DEPTH; i++)
            if (rt_valid[i] && rt_dest[i] == d) return i;
        return -1;
    endfunction

    function automatic int empty_slot();
        for (int i = 0; i < DEPTH; i++)
            if (!rt_valid[i]) return i;
        return -1;
    endfunction

    function automatic int route_cost(int i);
        return int'(rt_hops[i]) * 1000 - rt_metric[i];
    endfunction

    function automatic int worst_learned_slot();
        int w;
        w = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (!rt_valid[i] || rt_hops[i] <= 1) continue;
            if (w < 0 || route_cost(i) > route_cost(w)) w = i;
        end
        return w;
    endfunction

    function automatic void store_route(int i, logic [47:0] d, logic [47:0] via,
                                        int unsigned h, int m, logic [31:0] t);
        rt_valid[i] = 1'b1;
        rt_dest[i] = d;
        rt_via[i] = via;
        rt_hops[i] = h;
        rt_metric[i] = m;
        rt_stamp[i] = t;
    endfunction

    function automatic int merge_metric(int a, int b);
        if (a == -128) return b;
        if (b == -128) return a;
        return (a < b) ? a : b;
    endfunction

    function automatic outcome_t refresh_neighbour(logic [47:0] mac, int m, logic [31:0] t,
                                                   inout int removed);
        int i;
        i = route_slot(mac);
        if (i >= 0) begin
            store_route(i, mac, mac, 1, m, t);
            return OUT_UPDATED;
        end
        i = empty_slot();
        if (i < 0) begin
            i = worst_learned_slot();
            if (i < 0) return OUT_NONE;
            rt_valid[i] = 1'b0;
            removed++;
        end
        store_route(i, mac, mac, 1, m, t);
        return OUT_INSTALLED;
    endfunction

    function automatic outcome_t learn_route(route_item_t it, inout int removed);
        int unsigned nh;
        int nm, i, em, lm;
        bit shorter, better;
        em = $signed(it.emetric);
        lm = $signed(it.lmetric);
        if (it.dest == cfg_own_mac || it.dest == it.peer || it.hops == 0) return OUT_NONE;
        nh = it.hops + 1;
        if (nh > cfg_max_hops) return OUT_NONE;
        nm = merge_metric(em, lm);
        i = route_slot(it.dest);
        if (i >= 0) begin
            if (rt_hops[i] == 1) return OUT_NONE;
            if (rt_via[i] == it.peer) begin
                store_route(i, it.dest, it.peer, nh, nm, it.now);
                return OUT_UPDATED;
            end
            shorter = nh < rt_hops[i];
            better = nh == rt_hops[i] && nm != -128 &&
                     (rt_metric[i] == -128 || nm > rt_metric[i] + cfg_hysteresis);
            if (!shorter && !better) return OUT_NONE;
            store_route(i, it.dest, it.peer, nh, nm, it.now);
            return OUT_UPDATED;
        end
        i = empty_slot();
        if (i < 0) begin
            i = worst_learned_slot();
            if (i < 0 || rt_hops[i] <= nh) return OUT_NONE;
            rt_valid[i] = 1'b0;
            removed++;
        end
        store_route(i, it.dest, it.peer, nh, nm, it.now);
        return OUT_INSTALLED;
    endfunction

    function automatic route_result_t route_table_step(route_item_t it);
        route_result_t r;
        int removed, i, v;
        outcome_t oc;
        removed = 0;
        oc = OUT_NONE;
        r = '{default: '0};
        case (it.kind)
            KIND_HEARD: oc = refresh_neighbour(it.peer, $signed(it.lmetric), it.now, removed);
            KIND_ADVERT:
                if (it.registered && it.peer != cfg_own_mac) begin
                    void'(refresh_neighbour(it.peer, $signed(it.lmetric), it.now, removed));
                    oc = learn_route(it, removed);
                end
            KIND_LOST: begin
                i = route_slot(it.peer);
                if (i >= 0 && rt_hops[i] == 1) begin
                    rt_valid[i] = 1'b0;
                    removed++;
                end
                for (int k = 0; k < DEPTH; k++) begin
                    if (!rt_valid[k] || rt_hops[k] <= 1) continue;
                    v = route_slot(rt_via[k]);
                    if (v >= 0 && rt_hops[v] == 1) continue;
                    rt_valid[k] = 1'b0;
                    removed++;
                end
                oc = removed ? OUT_WITHDRAWN : OUT_NONE;
            end
            KIND_TICK: begin
                for (int k = 0; k < DEPTH; k++) begin
                    if (!rt_valid[k] || rt_hops[k] <= 1) continue;
                    if (it.now - rt_stamp[k] < cfg_expiry) continue;
                    rt_valid[k] = 1'b0;
                    removed++;
                end
                oc = removed ? OUT_WITHDRAWN : OUT_NONE;
            end
            KIND_LOOKUP: begin
                i = route_slot(it.dest);
                if (i >= 0) begin
                    r.hit = 1'b1;
                    r.next_hop = rt_via[i];
                    r.hops = rt_hops[i][7:0];
                    r.metric = rt_metric[i][7:0];
                end
            end
            default: ;
        endcase
        r.outcome = oc;
        r.removed = (removed > 63) ? 6'd63 : removed[5:0];
        return r;
    endfunction

    task automatic send_item(route_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        kind = it.kind;
        peer_mac = it.peer;
        dest_mac = it.dest;
        entry_hops = it.hops;
        entry_metric = it.emetric;
        link_metric = it.lmetric;
        peer_registered = it.registered;
        now_ms = it.now;
        item_valid = 1'b1;
        do @(posedge clk); while (!item_ready);
        pending_results.push_back(route_table_step(it));
    endtask

    task automatic drain();
        @(negedge clk);
        item_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(reg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_OWN_MAC:    cfg_own_mac = value[47:0];
            REG_MAX_HOPS:   cfg_max_hops = value[7:0];
            REG_HYSTERESIS: cfg_hysteresis = value[6:0];
            REG_EXPIRY:     cfg_expiry = value[31:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [47:0] own, int unsigned mh, int hy, logic [31:0] ex);
        drain();
        write_register(REG_OWN_MAC, own);
        write_register(REG_MAX_HOPS, mh);
        write_register(REG_HYSTERESIS, hy);
        write_register(REG_EXPIRY, ex);
    endtask

    function automatic route_item_t make_item(kind_t k, logic [47:0] p, logic [47:0] d,
                                              int h, int em, int lm, bit rg);
        route_item_t it;
        it.kind = k;
        it.peer = p;
        it.dest = d;
        it.hops = h[7:0];
        it.emetric = em[7:0];
        it.lmetric = lm[7:0];
        it.registered = rg;
        it.now = clock_ms;
        return it;
    endfunction

    function automatic route_item_t random_item();
        route_item_t it;
        int sel;
        clock_ms += $urandom_range(3000);
        sel = $urandom_range(99);
        it.kind = (sel < 50) ? KIND_ADVERT : (sel < 62) ? KIND_HEARD : (sel < 67) ? KIND_LOST :
                  (sel < 74) ? KIND_TICK : (sel < 96) ? KIND_LOOKUP : 3'($urandom_range(5, 7));
        it.peer = ($urandom_range(19) == 0) ? 48'({$urandom, $urandom}) :
                  peer_pool[$urandom_range(7)];
        it.dest = ($urandom_range(19) == 0) ? 48'({$urandom, $urandom}) :
                  ($urandom_range(9) == 0) ? peer_pool[$urandom_range(7)] :
                  dest_pool[$urandom_range(39)];
        if ($urandom_range(29) == 0) it.peer = cfg_own_mac;
        if ($urandom_range(29) == 0) it.dest = cfg_own_mac;
        it.hops = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        it.emetric = 8'($urandom);
        it.lmetric = 8'(-int'($urandom_range(128)));
        it.registered = ($urandom_range(9) != 0);
        it.now = ($urandom_range(49) == 0) ? $urandom : clock_ms;
        return it;
    endfunction

    task automatic test_directed();
        clock_ms = 32'd1000;
        send_item(make_item(KIND_LOOKUP, 0, dest_pool[0], 0, 0, 0, 0));
        send_item(make_item(KIND_HEARD, peer_pool[0], 0, 0, 0, -128, 0));
        send_item(make_item(KIND_HEARD, peer_pool[0], 0, 0, 0, 0, 0));
        send_item(make_item(KIND_ADVERT, peer_pool[0], dest_pool[0], 2, 127, -40, 1));
        send_item(make_item(KIND_ADVERT, peer_pool[1], dest_pool[0], 2, -20, -30, 1));
        send_item(make_item(KIND_ADVERT, peer_pool[2], dest_pool[0], 1, -128, -128, 1));
        send_item(make_item(KIND_ADVERT, peer_pool[3], dest_pool[1], 1, -128, -60, 0));
        send_item(make_item(KIND_ADVERT, peer_pool[3], peer_pool[3], 1, 0, -60, 1));
        send_item(make_item(KIND_ADVERT, peer_pool[3], dest_pool[1], 0, 0, -60, 1));
        send_item(make_item(KIND_ADVERT, peer_pool[3], dest_pool[1], 7, 0, -60, 1));
        send_item(make_item(KIND_ADVERT, peer_pool[3], dest_pool[1], 255, -128, -1, 1));
        send_item(make_item(KIND_ADVERT, peer_pool[3], cfg_own_mac, 2, 0, -60, 1));
        send_item(make_item(KIND_ADVERT, cfg_own_mac, dest_pool[1], 2, 0, -60, 1));
        send_item(make_item(KIND_ADVERT, peer_pool[0], peer_pool[3], 3, 0, -10, 1));
        send_item(make_item(KIND_LOOKUP, 0, dest_pool[0], 0, 0, 0, 0));
        send_item(make_item(KIND_LOOKUP, 0, peer_pool[0], 0, 0, 0, 0));
        send_item(make_item(KIND_LOST, peer_pool[1], 0, 0, 0, 0, 0));
        send_item(make_item(KIND_LOST, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0));
        clock_ms += 32'd40000;
        send_item(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0));
        for (int k = 5; k < 8; k++)
            send_item(make_item(kind_t'(k), '1, '1, 255, -1, -1, 1));
    endtask

    task automatic test_full_table();
        for (int i = 0; i < 30; i++)
            send_item(make_item(KIND_ADVERT, peer_pool[i % 2], dest_pool[i],
                                1 + i % 6, -int'(i), -50, 1));
        for (int i = 2; i < 8; i++)
            send_item(make_item(KIND_HEARD, peer_pool[i], 0, 0, 0, -70, 0));
        send_item(make_item(KIND_ADVERT, peer_pool[0], dest_pool[35], 1, -5, -50, 1));
        send_item(make_item(KIND_ADVERT, peer_pool[0], dest_pool[36], 6, -5, -50, 1));
        send_item(make_item(KIND_LOST, peer_pool[0], 0, 0, 0, 0, 0));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_item(random_item());
    endtask

    always @(negedge clk) result_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk) begin
        route_result_t exp_r;
        if (rst_n && result_valid && result_ready) begin
            if (pending_results.size() == 0) begin
                $display("%t: unexpected result outcome=%0d", $realtime, outcome);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (outcome !== exp_r.outcome || hit !== exp_r.hit ||
                    next_hop_mac !== exp_r.next_hop || hop_count !== exp_r.hops ||
                    route_metric !== exp_r.metric || removed_count !== exp_r.removed) begin
                    $display("%t: expected oc=%0d hit=%0d nh=%h hops=%0d m=%0d rm=%0d",
                             $realtime, exp_r.outcome, exp_r.hit, exp_r.next_hop,
                             exp_r.hops, $signed(exp_r.metric), exp_r.removed);
                    $display("%t: actual   oc=%0d hit=%0d nh=%h hops=%0d m=%0d rm=%0d",
                             $realtime, outcome, hit, next_hop_mac, hop_count,
                             route_metric, removed_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        cfg_own_mac = '0;
        cfg_max_hops = 8;
        cfg_hysteresis = 3;
        cfg_expiry = 32'd30000;
        foreach (rt_valid[i]) rt_valid[i] = 1'b0;
        foreach (peer_pool[i]) peer_pool[i] = 48'({$urandom, $urandom}) | 48'h1;
        foreach (dest_pool[i]) dest_pool[i] = 48'({$urandom, $urandom}) | 48'h2;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle = 13;
        recv_idle = 48;
        test_directed();
        test_full_table();
        test_random(120);

        configure(48'hFFFF_FFFF_FFFF, 255, 0, 32'd1);
        send_idle = 48;
        recv_idle = 13;
        send_item(make_item(KIND_ADVERT, peer_pool[4], dest_pool[3], 254, 127, -128, 1));
        send_item(make_item(KIND_ADVERT, peer_pool[4], dest_pool[4], 255, 1, 0, 1));
        test_random(120);

        configure(48'({$urandom, $urandom}), 1, 127, 32'hFFFF_FFFF);
        test_random(30);
        configure(dest_pool[5], 4, 0, 32'd0);
        send_idle = 0;
        recv_idle = 0;
        test_random(60);
        configure(48'd0, 8, 3, 32'd5000);
        test_random(60);
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/dvrt_pkg.sv
rtl/core/dvrt_ram.sv
rtl/core/dvrt_eval.sv
rtl/core/distance_vector_route_table.sv
bench/distance_vector_route_table_tb.sv
